// ===== hw/rtl/pngunf_pkg.sv =====
package pngunf_pkg;

    // Row filter codes; a type above four is kept as FILT_BAD.
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [2:0] FILT_BAD   = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_COLOR_MODE   = 2'd2;

    localparam int CFG_DATA_W = 16;

    // Output queue depth, last pointer value and full count.
    localparam int          OQ_DEPTH  = 3;
    localparam logic [1:0]  OQ_LAST   = 2'd2;
    localparam logic [2:0]  OQ_FULL   = 3'd3;

    // Word held between the accept stage and the reconstruct stage.
    typedef struct packed {
        logic       is_sample;
        logic [2:0] filt;
        logic       row_zero;
        logic [1:0] chan;
        logic       row_last;
        logic       image_last;
        logic [7:0] raw;
    } stage_t;

    // Entry of the output queue.
    typedef struct packed {
        logic [7:0] pixel;
        logic       row_last;
        logic       image_last;
        logic       bad_filter;
    } result_t;

endpackage

// ===== hw/rtl/pngunf_ram.sv =====
module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12288
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/png_scanline_unfilter.sv =====
// PNG scanline unfilter.
// Input stream (s_t*): one byte of the inflated image stream per word. The
// first word of each row is the filter type and yields no output word; each
// following word is a filtered sample, rebuilt with none, sub, up, average or
// Paeth. Output stream (m_t*): one reconstructed sample per word, tlast on the
// last sample of a row, tuser carrying the end-of-image and bad-filter flags.
// Configuration: cfg_we writes register cfg_index (0 width, 1 height,
// 2 color mode) on the clock edge; write only between images or between words.
// Throughput: one word per cycle while s_tready is high, set by one line-store
// read and one line-store write per cycle (the write trails the read by one
// stage). An accepted sample goes through the stage register into the output
// queue, which drives m_tvalid. The previous row lives in a 3*MAX_WIDTH byte
// line store; the first row of an image reads its upper neighbors as zero.
// Reset: aresetn (synchronous, low) clears all control state, then the block
// sweeps every line-store address to zero with s_tready low.
// Stall: a three-word output queue absorbs the word in flight; s_tready drops
// when the queue plus the stage in flight would overflow, and during the sweep.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] raw_byte
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] pixel_byte
    output logic                               m_tlast,   // row_last
    output logic [1:0]                         m_tuser    // [0] image_last, [1] bad_filter
);

    import pngunf_pkg::*;

    localparam int DEPTH  = 3 * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W  = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        color_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 13'd1;
            image_height_reg <= 16'd1;
            color_mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[12:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[15:0];
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Paeth predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] p;
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
        da = p - $signed({3'b000, a});
        db = p - $signed({3'b000, b});
        dc = p - $signed({3'b000, c});
        pa = (da < 0) ? 11'(-da) : 11'(da);
        pb = (db < 0) ? 11'(-db) : 11'(db);
        pc = (dc < 0) ? 11'(-dc) : 11'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stage 0: accept, position tracking, line-store read
    // ------------------------------------------------------------------
    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    logic              awaiting_reg,  awaiting_next;
    logic [2:0]        row_filter_reg, row_filter_next;
    logic [COL_W-1:0]  col_reg,       col_next;
    logic [1:0]        chan_reg,      chan_next;
    logic [15:0]       row_reg,       row_next;

    logic              p1_valid_reg;
    stage_t            p1_reg,        p1_next;
    logic [ADDR_W-1:0] p1_addr_reg,   rd_addr;

    logic [2:0]        oq_count_reg,  oq_count_next;

    logic              s_accept;
    logic [1:0]        chan_k;
    logic [CMP_W-1:0]  eff_width;
    logic [16:0]       eff_height;
    logic              last_ch;
    logic              last_col;
    logic              last_row;
    logic              p1_push;

    assign p1_push  = p1_valid_reg && p1_reg.is_sample;
    assign s_tready = !clear_active_reg && ((oq_count_reg + {2'b00, p1_push}) < OQ_FULL);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        chan_k = (chan_reg > 2'd2) ? 2'd2 : chan_reg;

        if (image_width_reg == 13'd0) begin
            eff_width = CMP_W'(1);
        end else if (CMP_W'(image_width_reg) > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = CMP_W'(image_width_reg);
        end
        eff_height = (image_height_reg == 16'd0) ? 17'd1 : {1'b0, image_height_reg};

        last_ch  = ({1'b0, chan_reg} + 3'd1) >= (color_mode_reg ? 3'd3 : 3'd1);
        last_col = last_ch && ((CMP_W'(col_reg) + CMP_W'(1)) >= eff_width);
        last_row = last_col && (({1'b0, row_reg} + 17'd1) >= eff_height);

        rd_addr = ADDR_W'((ADDR_W'(col_reg) << 1) + ADDR_W'(col_reg) + ADDR_W'(chan_k));

        awaiting_next   = awaiting_reg;
        row_filter_next = row_filter_reg;
        col_next        = col_reg;
        chan_next       = chan_reg;
        row_next        = row_reg;

        p1_next.is_sample  = !awaiting_reg;
        p1_next.filt       = row_filter_reg;
        p1_next.row_zero   = (row_reg == 16'd0);
        p1_next.chan       = chan_k;
        p1_next.row_last   = last_col;
        p1_next.image_last = last_row;
        p1_next.raw        = s_tdata;

        if (s_accept) begin
            if (awaiting_reg) begin
                // filter byte: latch the type and open the row
                row_filter_next = (s_tdata > 8'd4) ? FILT_BAD : s_tdata[2:0];
                awaiting_next   = 1'b0;
                col_next        = '0;
                chan_next       = 2'd0;
            end else if (!last_ch) begin
                chan_next = chan_reg + 2'd1;
            end else if (!last_col) begin
                chan_next = 2'd0;
                col_next  = col_reg + COL_W'(1);
            end else begin
                awaiting_next = 1'b1;
                row_next      = last_row ? 16'd0 : row_reg + 16'd1;
                col_next      = '0;
                chan_next     = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg   <= 1'b1;
            row_filter_reg <= FILT_NONE;
            col_reg        <= '0;
            chan_reg       <= 2'd0;
            row_reg        <= 16'd0;
            p1_valid_reg   <= 1'b0;
        end else begin
            awaiting_reg   <= awaiting_next;
            row_filter_reg <= row_filter_next;
            col_reg        <= col_next;
            chan_reg       <= chan_next;
            row_reg        <= row_next;
            p1_valid_reg   <= s_accept;
        end
    end

    // stage payload carries no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg      <= p1_next;
            p1_addr_reg <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Line store with the post-reset clearing sweep
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [7:0]        ram_rd_data;
    logic [7:0]        recon;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end else if (clear_active_reg) begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == LAST_ADDR) begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    assign ram_we      = clear_active_reg || p1_push;
    assign ram_wr_addr = clear_active_reg ? clear_addr_reg : p1_addr_reg;
    assign ram_wr_data = clear_active_reg ? 8'd0 : recon;

    pngunf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept && !awaiting_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: reconstruct, write back, push to output queue
    // ------------------------------------------------------------------
    logic [7:0] left_reg   [3];
    logic [7:0] left_next  [3];
    logic [7:0] upleft_reg [3];
    logic [7:0] upleft_next[3];
    logic [7:0] nb_a;
    logic [7:0] nb_b;
    logic [7:0] nb_c;
    logic [8:0] avg_sum;

    always_comb begin
        nb_a    = left_reg[p1_reg.chan];
        nb_b    = p1_reg.row_zero ? 8'd0 : ram_rd_data;
        nb_c    = p1_reg.row_zero ? 8'd0 : upleft_reg[p1_reg.chan];
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

        case (p1_reg.filt)
            FILT_SUB:   recon = p1_reg.raw + nb_a;
            FILT_UP:    recon = p1_reg.raw + nb_b;
            FILT_AVG:   recon = p1_reg.raw + avg_sum[8:1];
            FILT_PAETH: recon = p1_reg.raw + paeth_pick(nb_a, nb_b, nb_c);
            default:    recon = p1_reg.raw;
        endcase

        for (int i = 0; i < 3; i++) begin
            left_next[i]   = left_reg[i];
            upleft_next[i] = upleft_reg[i];
        end
        if (p1_valid_reg) begin
            if (p1_reg.is_sample) begin
                left_next[p1_reg.chan]   = recon;
                upleft_next[p1_reg.chan] = nb_b;
            end else begin
                // filter byte opens a row: drop the left neighbors
                for (int i = 0; i < 3; i++) begin
                    left_next[i]   = 8'd0;
                    upleft_next[i] = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= 8'd0;
                upleft_reg[i] <= 8'd0;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                left_reg[i]   <= left_next[i];
                upleft_reg[i] <= upleft_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    result_t    oq_mem [OQ_DEPTH];
    result_t    oq_in;
    logic [1:0] oq_wr_reg;
    logic [1:0] oq_rd_reg;
    logic       oq_pop;

    assign oq_in.pixel      = recon;
    assign oq_in.row_last   = p1_reg.row_last;
    assign oq_in.image_last = p1_reg.image_last;
    assign oq_in.bad_filter = (p1_reg.filt == FILT_BAD);

    assign m_tvalid = (oq_count_reg != 3'd0);
    assign oq_pop   = m_tvalid && m_tready;
    assign m_tdata  = oq_mem[oq_rd_reg].pixel;
    assign m_tlast  = oq_mem[oq_rd_reg].row_last;
    assign m_tuser  = {oq_mem[oq_rd_reg].bad_filter, oq_mem[oq_rd_reg].image_last};

    assign oq_count_next = oq_count_reg + {2'b00, p1_push} - {2'b00, oq_pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_reg    <= 2'd0;
            oq_rd_reg    <= 2'd0;
            oq_count_reg <= 3'd0;
        end else begin
            oq_count_reg <= oq_count_next;
            if (p1_push) begin
                oq_wr_reg <= (oq_wr_reg == OQ_LAST) ? 2'd0 : oq_wr_reg + 2'd1;
            end
            if (oq_pop) begin
                oq_rd_reg <= (oq_rd_reg == OQ_LAST) ? 2'd0 : oq_rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_push) begin
            oq_mem[oq_wr_reg] <= oq_in;
        end
    end

`ifndef SYNTHESIS
    // hold off input for the whole clearing sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_active_reg |-> !s_tready)
        else $error("input accepted during line-store clear");

    // a word in the reconstruct stage was accepted in the previous cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> $past(s_accept))
        else $error("reconstruct stage holds a word that was never accepted");

    // the output queue never overflows
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_push && oq_count_reg == OQ_FULL) |-> oq_pop)
        else $error("output queue overflow");

    // end of image always ends a row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("image end without row end");

    // a row ends only on the last byte of a pixel, so the next word is a filter byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !awaiting_reg && last_col) |=> awaiting_reg)
        else $error("row end did not return to filter byte");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import pngunf_pkg::*;

    localparam int MAX_W         = 4096;
    localparam int STORE_DEPTH   = 3 * MAX_W;
    // Cycles to let a trailing filter word settle before a register write.
    localparam int SETTLE_CYCLES = 8;
    // Length of the one long receiver hold-off.
    localparam int HOLD_CYCLES   = 240;
    // Watchdog limit for the whole run, including the line store sweep.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Tracking contexts: one follows accepted words, one plans the stimulus.
    localparam int PRED = 0;
    localparam int PLAN = 1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;    // [7:0] raw_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // [7:0] pixel_byte
    logic                  m_tlast;           // row_last
    logic [1:0]            m_tuser;           // [0] image_last, [1] bad_filter

    png_scanline_unfilter #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Register copy, written together with the block's registers.
    logic [12:0] img_width  = 13'd1;
    logic [15:0] img_height = 16'd1;
    logic        color_rgb  = 1'b0;

    // Unfilter state, one copy per tracking context.
    logic [7:0]  prev_row    [2][STORE_DEPTH];
    logic [7:0]  left_px     [2][3];
    logic [7:0]  upleft_px   [2][3];
    logic [2:0]  row_filt    [2];
    logic [11:0] col_pos     [2];
    logic [1:0]  chan_pos    [2];
    logic [15:0] row_pos     [2];
    bit          want_filter [2];

    logic [7:0] pending_bytes[$];     // words waiting to be driven
    result_t    expected_pixels[$];   // reconstructed samples not yet seen
    result_t    taken_res;
    result_t    oldest_pixel;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int pushed_count      = 0;
    int mismatch_count    = 0;
    int cycle_count       = 0;
    logic hold_req        = 1'b0;
    int   hold_left       = 0;

    function automatic void start_row(input int cx);
        for (int i = 0; i < 3; i++) begin
            left_px[cx][i]   = 8'd0;
            upleft_px[cx][i] = 8'd0;
        end
        col_pos[cx]  = 12'd0;
        chan_pos[cx] = 2'd0;
    endfunction

    // Take one stream word; return 1 with the rebuilt sample when it was a sample.
    function automatic bit unfilter_byte(input int cx, input logic [7:0] x,
                                         output result_t res);
        int unsigned bpp, width, height, k, idx;
        int ia, ib, ic, p, pa, pb, pc;
        logic [7:0] left_nb, up_nb, diag_nb, pix;
        bit last_ch, last_col, last_row;

        res    = '0;
        bpp    = color_rgb ? 3 : 1;
        width  = (img_width == 0) ? 1 : ((img_width > MAX_W) ? MAX_W : int'(img_width));
        height = (img_height == 0) ? 1 : int'(img_height);

        if (want_filter[cx]) begin
            // any type above Paeth is kept as the bad marker
            row_filt[cx]    = (x > 8'(FILT_PAETH)) ? FILT_BAD : x[2:0];
            want_filter[cx] = 1'b0;
            start_row(cx);
            return 1'b0;
        end

        k   = (chan_pos[cx] > 2'd2) ? 2 : int'(chan_pos[cx]);
        idx = int'(col_pos[cx]) * 3 + k;
        if (idx >= STORE_DEPTH) idx = STORE_DEPTH - 1;

        // the first row of an image sees zeros above
        left_nb = left_px[cx][k];
        up_nb   = (row_pos[cx] == 0) ? 8'd0 : prev_row[cx][idx];
        diag_nb = (row_pos[cx] == 0) ? 8'd0 : upleft_px[cx][k];
        ia = int'(left_nb);
        ib = int'(up_nb);
        ic = int'(diag_nb);

        case (row_filt[cx])
            FILT_SUB:   pix = x + left_nb;
            FILT_UP:    pix = x + up_nb;
            FILT_AVG:   pix = x + 8'((ia + ib) >> 1);
            FILT_PAETH: begin
                p  = ia + ib - ic;
                pa = (p > ia) ? p - ia : ia - p;
                pb = (p > ib) ? p - ib : ib - p;
                pc = (p > ic) ? p - ic : ic - p;
                if (pa <= pb && pa <= pc) pix = x + left_nb;
                else if (pb <= pc)        pix = x + up_nb;
                else                      pix = x + diag_nb;
            end
            default:    pix = x;
        endcase

        prev_row[cx][idx] = pix;
        left_px[cx][k]    = pix;
        upleft_px[cx][k]  = up_nb;

        // a position at or past a shrunken limit counts as the last one
        last_ch  = (int'(chan_pos[cx]) + 1) >= bpp;
        last_col = last_ch && ((int'(col_pos[cx]) + 1) >= width);
        last_row = last_col && ((int'(row_pos[cx]) + 1) >= height);

        res.pixel      = pix;
        res.row_last   = last_col;
        res.image_last = last_row;
        res.bad_filter = (row_filt[cx] == FILT_BAD);

        if (!last_ch) begin
            chan_pos[cx] = chan_pos[cx] + 2'd1;
        end else if (!last_col) begin
            chan_pos[cx] = 2'd0;
            col_pos[cx]  = col_pos[cx] + 12'd1;
        end else begin
            want_filter[cx] = 1'b1;
            row_pos[cx]     = last_row ? 16'd0 : row_pos[cx] + 16'd1;
            start_row(cx);
        end
        return 1'b1;
    endfunction

    // Queue one word for the driver and advance the planning context with it.
    task automatic push_byte(input logic [7:0] b);
        result_t unused;
        pending_bytes.push_back(b);
        void'(unfilter_byte(PLAN, b, unused));
        pushed_count++;
    endtask

    // Queue at least min_bytes words, then complete the image in progress.
    // A filter word is a bad type with probability bad_pct.
    task automatic queue_stream(input int min_bytes, input int bad_pct);
        int n;
        logic [7:0] b;
        n = 0;
        while (n < min_bytes || !(want_filter[PLAN] && row_pos[PLAN] == 0)) begin
            if (want_filter[PLAN]) begin
                if ($urandom_range(0, 99) < bad_pct)
                    b = 8'($urandom_range(int'(FILT_BAD), 255));
                else
                    b = 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
            end else begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            push_byte(b);
            n++;
        end
    endtask

    // Wait until every word is taken and every sample is back, then settle.
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            CFG_IMAGE_WIDTH:  img_width  = val[12:0];
            CFG_IMAGE_HEIGHT: img_height = val[15:0];
            CFG_COLOR_MODE:   color_rgb  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h, input int unsigned m);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_COLOR_MODE, m);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random image shapes, mostly small; zero width and height show up now and then.
    task automatic run_random(input int n);
        int stop;
        int unsigned w, h, sel;
        stop = pushed_count + n;
        while (pushed_count < stop) begin
            wait_idle();
            sel = $urandom_range(0, 99);
            if (sel < 5)       w = 0;
            else if (sel < 70) w = $urandom_range(1, 8);
            else               w = $urandom_range(9, 48);
            sel = $urandom_range(0, 99);
            h = (sel < 5) ? 0 : $urandom_range(1, 6);
            set_image(w, h, $urandom_range(0, 1));
            queue_stream($urandom_range(10, 80), 6);
        end
    endtask

    // Driver: take the handshake, then offer the next word or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // predict every accepted word in acceptance order
            if (s_tvalid && s_tready) begin
                if (unfilter_byte(PRED, s_tdata, taken_res))
                    expected_pixels.push_back(taken_res);
            end
            // hold the word until taken; only then advance or idle
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    s_tdata  <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and seen by the monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each taken sample with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected word: pixel_byte %0d row_last %0b tuser %b",
                           m_tdata, m_tlast, m_tuser);
                    mismatch_count++;
                end else begin
                    oldest_pixel = expected_pixels.pop_front();
                    if (m_tdata !== oldest_pixel.pixel) begin
                        $error("pixel_byte: expected %0d, got %0d", oldest_pixel.pixel, m_tdata);
                        mismatch_count++;
                    end
                    if (m_tlast !== oldest_pixel.row_last) begin
                        $error("row_last: expected %0b, got %0b", oldest_pixel.row_last, m_tlast);
                        mismatch_count++;
                    end
                    if (m_tuser[0] !== oldest_pixel.image_last) begin
                        $error("image_last: expected %0b, got %0b",
                               oldest_pixel.image_last, m_tuser[0]);
                        mismatch_count++;
                    end
                    if (m_tuser[1] !== oldest_pixel.bad_filter) begin
                        $error("bad_filter: expected %0b, got %0b",
                               oldest_pixel.bad_filter, m_tuser[1]);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog over the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        // clear both tracking contexts to the reset state
        for (int cx = 0; cx < 2; cx++) begin
            for (int i = 0; i < STORE_DEPTH; i++) prev_row[cx][i] = 8'd0;
            row_filt[cx]    = FILT_NONE;
            row_pos[cx]     = 16'd0;
            want_filter[cx] = 1'b1;
            start_row(cx);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // hold off until the line store sweep is over
        while (s_tready !== 1'b1) @(posedge aclk);

        // sender idles a little, receiver a lot
        sender_idle_pct   = 9;
        receiver_idle_pct = 63;

        // first row: Paeth falls back to the left neighbor; zero and full bytes
        set_image(2, 3, 0);
        push_byte(8'(FILT_PAETH)); push_byte(8'hFF); push_byte(8'h00);
        push_byte(8'(FILT_UP));    push_byte(8'h80); push_byte(8'hFF);
        // smallest bad type: row passes through with the flag set
        push_byte(8'(FILT_BAD));   push_byte(8'h12); push_byte(8'hFF);
        wait_idle();

        // sub and average with wraparound
        set_image(2, 2, 0);
        push_byte(8'(FILT_SUB));   push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'(FILT_AVG));   push_byte(8'hFF); push_byte(8'h01);
        wait_idle();

        // shrink width, height and color mode in the middle of a pixel:
        // the next sample closes the row, the next row closes the image
        set_image(6, 5, 1);
        push_byte(8'(FILT_NONE));
        repeat (7) push_byte(8'($urandom_range(0, 255)));
        wait_idle();
        set_image(2, 2, 0);
        queue_stream(0, 0);

        run_random(350);

        // sender idles a lot, receiver a little
        sender_idle_pct   = 63;
        receiver_idle_pct = 9;
        run_random(350);

        // no idling; drop tready for a long stretch so the block backs up
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        wait_idle();
        set_image(4, 8, 1);
        queue_stream(200, 6);
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        run_random(200);

        // register extremes: oversized width and tallest image, cut short by
        // shrinking both to one in the middle of the first row
        wait_idle();
        set_image(8191, 65535, 1);
        push_byte(8'(FILT_SUB));
        repeat (20) push_byte(8'($urandom_range(0, 255)));
        wait_idle();
        set_image(1, 1, 0);
        queue_stream(0, 0);

        // zero width and height act as one
        wait_idle();
        set_image(0, 0, 1);
        queue_stream(1, 0);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
